@@ src/bdq_pkg.sv @@
// Shared constants, request codes, controller/datapath handshake structs
// and the index wrap helper for the bounded double-ended queue.
// No dependencies.
`default_nettype none

package bdq_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int REQ_W      = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_REPORT     = 3'd4
	} req_kind_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the incoming word
		logic exec;      // carry out the request
		logic load;      // refresh the cached end word from the store
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_load; // a pop left words behind, the new end must be read
	} dp_status_t;

	// Add two positions modulo CAPACITY, both below CAPACITY.
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (IDX_W+1)'(CAPACITY)) begin
			sum = sum - (IDX_W+1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ src/bdq_if.sv @@
// Valid/ready channel interfaces for request words and result words.
// Depends on bdq_pkg.
`default_nettype none

interface bdq_req_if import bdq_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [REQ_W-1:0]      req_type;
	logic [DATA_WIDTH-1:0] data_in;

	modport source (output valid, output req_type, output data_in, input ready);
	modport sink   (input valid, input req_type, input data_in, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  ok;
	logic [DATA_WIDTH-1:0] popped_data;
	logic [DATA_WIDTH-1:0] front_data;
	logic [DATA_WIDTH-1:0] back_data;
	logic [CNT_W-1:0]      occupancy;
	logic                  is_empty;
	logic                  is_full;

	modport source (output valid, output ok, output popped_data, output front_data,
		output back_data, output occupancy, output is_empty, output is_full,
		input ready);
	modport sink   (input valid, input ok, input popped_data, input front_data,
		input back_data, input occupancy, input is_empty, input is_full,
		output ready);
endinterface

`default_nettype wire

@@ src/bounded_double_ended_queue.sv @@
// Bounded double-ended queue of CAPACITY data words on a circular buffer.
// Depends on bdq_pkg, bdq_req_if, bdq_rsp_if, bdq_ctrl, bdq_datapath.
//
// Usage:
//   req channel: one word per request, req_type selects push front, push
//   back, pop front, pop back or report; data_in is the word to push.
//   rsp channel: one word per request with ok, the popped word, the front
//   and back words, the occupancy and the empty/full flags after the request.
//   A push to a full queue or a pop from an empty queue returns ok low and
//   leaves the queue unchanged; undefined request codes do the same.
// Timing:
//   One request is handled at a time. After the accepting edge it passes
//   the execute and respond states, with a store read state between them
//   for a pop that leaves words behind: the new end word is then read from
//   the single registered read port of the store. The next request is taken
//   only after the response has been accepted and the sequencer is idle.
// Reset and stall:
//   arst_n empties the queue (head and count cleared); the store is not
//   cleared. While rsp.ready is low the response word holds and req.ready
//   stays low.
`default_nettype none

module bounded_double_ended_queue import bdq_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	bdq_req_if.sink   req,
	bdq_rsp_if.source rsp
);

	dp_cmd_t    cmd;
	dp_status_t status;

	bdq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	bdq_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.req_type    (req.req_type),
		.data_in     (req.data_in),
		.ok          (rsp.ok),
		.popped_data (rsp.popped_data),
		.front_data  (rsp.front_data),
		.back_data   (rsp.back_data),
		.occupancy   (rsp.occupancy),
		.is_empty    (rsp.is_empty),
		.is_full     (rsp.is_full)
	);

	// occupancy stays within capacity
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.occupancy <= CNT_W'(CAPACITY))
		else $error("occupancy above capacity");

	// an accepted request is executed in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> cmd.exec)
		else $error("accepted request not executed");

	// never take a request while a response is pending
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid))
		else $error("request accepted with response pending");

	// a response appears only right after execute or store read
	a_resp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(cmd.exec) || $past(cmd.load))
		else $error("response without execution");

endmodule

`default_nettype wire

@@ src/bdq_ctrl.sv @@
// Sequencer for the queue: accept, execute, optional store read, respond.
// Depends on bdq_pkg.
`default_nettype none

module bdq_ctrl import bdq_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_LOAD = 4'b0100,
		ST_RESP = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// advance the sequence
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				state_d = status.need_load ? ST_LOAD : ST_RESP;
			end
			ST_LOAD: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// drive handshakes and datapath commands
	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_RESP);
	assign cmd.capture = in_ready && in_valid;
	assign cmd.exec    = (state_q == ST_EXEC);
	assign cmd.load    = (state_q == ST_LOAD);

endmodule

`default_nettype wire

@@ src/bdq_datapath.sv @@
// Circular-buffer store, head and count registers, cached end words and
// result registers of the queue. Depends on bdq_pkg.
`default_nettype none

module bdq_datapath import bdq_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dp_cmd_t               cmd,
	output dp_status_t                 status,
	input  wire logic [REQ_W-1:0]      req_type,
	input  wire logic [DATA_WIDTH-1:0] data_in,
	output logic                       ok,
	output logic [DATA_WIDTH-1:0]      popped_data,
	output logic [DATA_WIDTH-1:0]      front_data,
	output logic [DATA_WIDTH-1:0]      back_data,
	output logic [CNT_W-1:0]           occupancy,
	output logic                       is_empty,
	output logic                       is_full
);

	logic [DATA_WIDTH-1:0] mem_q [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_data_q;
	logic [REQ_W-1:0]      req_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [IDX_W-1:0]      head_q;
	logic [CNT_W-1:0]      count_q;
	logic [DATA_WIDTH-1:0] front_q;
	logic [DATA_WIDTH-1:0] back_q;
	logic [DATA_WIDTH-1:0] popped_q;
	logic                  ok_q;

	logic                  empty;
	logic                  full;
	logic [IDX_W-1:0]      head_inc;
	logic [IDX_W-1:0]      head_dec;
	logic [IDX_W-1:0]      back_off;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	logic [IDX_W-1:0]      rd_addr;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign head_inc = (head_q == IDX_W'(CAPACITY - 1)) ? '0 : head_q + IDX_W'(1);
	assign head_dec = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - IDX_W'(1);

	// a pop needs a store read when at least one word stays behind
	always_comb begin
		status.need_load = 1'b0;
		if (count_q > CNT_W'(1)) begin
			if (req_q == REQ_POP_FRONT || req_q == REQ_POP_BACK) status.need_load = 1'b1;
		end
	end

	// offset of the new back word after a pop from the back
	assign back_off = status.need_load ? IDX_W'(count_q - CNT_W'(2)) : '0;

	// select store write and read positions
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = head_dec;
		rd_addr = head_inc;
		if (cmd.exec && !full) begin
			if (req_q == REQ_PUSH_FRONT) begin
				wr_en   = 1'b1;
				wr_addr = head_dec;
			end else if (req_q == REQ_PUSH_BACK) begin
				wr_en   = 1'b1;
				wr_addr = wrap_add(head_q, count_q[IDX_W-1:0]);
			end
		end
		if (req_q == REQ_POP_BACK) rd_addr = wrap_add(head_q, back_off);
	end

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= data_q;
		rd_data_q <= mem_q[rd_addr];
	end

	// latch the accepted request word
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req_type;
			data_q <= data_in;
		end
	end

	// update head and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			case (req_q)
				REQ_PUSH_FRONT: begin
					if (!full) begin
						head_q  <= head_dec;
						count_q <= count_q + CNT_W'(1);
					end
				end
				REQ_PUSH_BACK: begin
					if (!full) count_q <= count_q + CNT_W'(1);
				end
				REQ_POP_FRONT: begin
					if (!empty) begin
						head_q  <= head_inc;
						count_q <= count_q - CNT_W'(1);
					end
				end
				REQ_POP_BACK: begin
					if (!empty) count_q <= count_q - CNT_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	// hold result, cached front and back words
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			ok_q     <= 1'b0;
			popped_q <= '0;
			case (req_q)
				REQ_PUSH_FRONT: begin
					if (!full) begin
						ok_q    <= 1'b1;
						front_q <= data_q;
						if (empty) back_q <= data_q;
					end
				end
				REQ_PUSH_BACK: begin
					if (!full) begin
						ok_q   <= 1'b1;
						back_q <= data_q;
						if (empty) front_q <= data_q;
					end
				end
				REQ_POP_FRONT: begin
					if (!empty) begin
						ok_q     <= 1'b1;
						popped_q <= front_q;
					end
				end
				REQ_POP_BACK: begin
					if (!empty) begin
						ok_q     <= 1'b1;
						popped_q <= back_q;
					end
				end
				REQ_REPORT: begin
					ok_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end else if (cmd.load) begin
			if (req_q == REQ_POP_FRONT) begin
				front_q <= rd_data_q;
			end else begin
				back_q <= rd_data_q;
			end
		end
	end

	// drive the result word
	assign ok          = ok_q;
	assign popped_data = popped_q;
	assign front_data  = empty ? '0 : front_q;
	assign back_data   = empty ? '0 : back_q;
	assign occupancy   = count_q;
	assign is_empty    = empty;
	assign is_full     = full;

endmodule

`default_nettype wire

@@ tb/bounded_double_ended_queue_test.sv @@
// Self-checking testbench for the bounded double-ended queue: drives request
// words with random gaps and stalls, predicts every result word and checks it.
// Depends on bdq_pkg, bdq_req_if, bdq_rsp_if and bounded_double_ended_queue.
`timescale 1ns / 1ps

module bounded_double_ended_queue_test;
	import bdq_pkg::*;

	localparam logic [REQ_W-1:0] REQ_CODE_MAX = '1;
	localparam int               RANDOM_WORDS = 1350;
	localparam int               MAX_WAIT     = 12;
	localparam int               HOLD_CYCLES  = 80;

	typedef struct {
		logic [REQ_W-1:0]      kind;
		logic [DATA_WIDTH-1:0] word;
	} request_word_t;

	typedef struct {
		logic                  ok;
		logic [DATA_WIDTH-1:0] popped;
		logic [DATA_WIDTH-1:0] front;
		logic [DATA_WIDTH-1:0] back;
		logic [CNT_W-1:0]      occupancy;
		logic                  empty;
		logic                  full;
	} queue_status_t;

	logic clk;
	logic arst_n;

	bdq_req_if req_ch ();
	bdq_rsp_if rsp_ch ();

	bounded_double_ended_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the deque contents
	logic [DATA_WIDTH-1:0] shadow_slots [CAPACITY];
	int                    shadow_head  = 0;
	int                    shadow_count = 0;

	request_word_t pending_requests [$];
	queue_status_t status_due [$];

	int total_requests = 0;
	int words_accepted = 0;
	int mismatches     = 0;
	int send_gap       = 0;
	int recv_gap       = 0;
	bit send_burst     = 1'b0;
	bit recv_burst     = 1'b0;
	bit req_taken      = 1'b0;
	bit rsp_taken      = 1'b0;
	bit hold_off       = 1'b0;

	// Apply one request to the shadow deque and return the status it leaves
	function automatic queue_status_t deque_apply(input logic [REQ_W-1:0] kind,
		input logic [DATA_WIDTH-1:0] word);
		queue_status_t res;
		res = '{default: '0};
		case (kind)
			REQ_PUSH_FRONT: begin
				if (shadow_count < CAPACITY) begin
					shadow_head = (shadow_head + CAPACITY - 1) % CAPACITY;
					shadow_slots[shadow_head] = word;
					shadow_count++;
					res.ok = 1'b1;
				end
			end
			REQ_PUSH_BACK: begin
				if (shadow_count < CAPACITY) begin
					shadow_slots[(shadow_head + shadow_count) % CAPACITY] = word;
					shadow_count++;
					res.ok = 1'b1;
				end
			end
			REQ_POP_FRONT: begin
				if (shadow_count > 0) begin
					res.popped = shadow_slots[shadow_head];
					shadow_head = (shadow_head + 1) % CAPACITY;
					shadow_count--;
					res.ok = 1'b1;
				end
			end
			REQ_POP_BACK: begin
				if (shadow_count > 0) begin
					res.popped = shadow_slots[(shadow_head + shadow_count - 1) % CAPACITY];
					shadow_count--;
					res.ok = 1'b1;
				end
			end
			REQ_REPORT: begin
				res.ok = 1'b1;
			end
			default: begin
				// undefined code: refused, nothing changes
			end
		endcase
		if (shadow_count > 0) begin
			res.front = shadow_slots[shadow_head];
			res.back  = shadow_slots[(shadow_head + shadow_count - 1) % CAPACITY];
		end
		res.occupancy = CNT_W'(shadow_count);
		res.empty     = (shadow_count == 0);
		res.full      = (shadow_count == CAPACITY);
		return res;
	endfunction

	function automatic int draw_wait(input bit burst);
		return burst ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	task automatic flag_mismatch(input string what, input logic [DATA_WIDTH-1:0] got,
		input logic [DATA_WIDTH-1:0] want);
		$display("[%0t] MISMATCH %s: got %h, want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic queue_request(input logic [REQ_W-1:0] kind,
		input logic [DATA_WIDTH-1:0] word);
		request_word_t item;
		item.kind = kind;
		item.word = word;
		pending_requests.push_back(item);
		total_requests++;
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Reset and known input levels
	initial begin
		arst_n          = 1'b0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = '0;
		req_ch.data_in  = '0;
		rsp_ch.ready    = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Request driver: hold each word until taken, then wait its gap
	always @(negedge clk) begin : drive_requests
		request_word_t nxt;
		if (arst_n) begin
			if (req_ch.valid && !req_taken) begin
				// hold the word
			end else if (send_gap > 0) begin
				req_ch.valid <= 1'b0;
				send_gap     <= send_gap - 1;
			end else if (pending_requests.size() > 0) begin
				nxt = pending_requests.pop_front();
				req_ch.valid    <= 1'b1;
				req_ch.req_type <= nxt.kind;
				req_ch.data_in  <= nxt.word;
				send_gap        <= draw_wait(send_burst);
				if ($urandom_range(0, 29) == 0) begin
					send_burst <= !send_burst;
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: stall a random number of cycles after each word
	always @(negedge clk) begin : drive_ready
		int g;
		if (arst_n) begin
			if (hold_off) begin
				rsp_ch.ready <= 1'b0;
			end else if (rsp_taken) begin
				g = draw_wait(recv_burst);
				rsp_ch.ready <= (g == 0);
				recv_gap     <= (g > 0) ? g - 1 : 0;
				if ($urandom_range(0, 29) == 0) begin
					recv_burst <= !recv_burst;
				end
			end else if (recv_gap > 0) begin
				rsp_ch.ready <= 1'b0;
				recv_gap     <= recv_gap - 1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Long receiver hold-offs so the queue backs up and stalls requests
	initial begin : long_hold
		int threshold;
		for (threshold = 300; threshold <= 900; threshold += 600) begin
			while (words_accepted < threshold) @(posedge clk);
			hold_off <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_off <= 1'b0;
		end
	end

	// Monitor: predict on each accepted request, check each accepted result
	always @(posedge clk) begin : watch_channels
		queue_status_t got;
		queue_status_t want;
		if (arst_n) begin
			req_taken <= req_ch.valid && req_ch.ready;
			rsp_taken <= rsp_ch.valid && rsp_ch.ready;
			if (req_ch.valid && req_ch.ready) begin
				status_due.push_back(deque_apply(req_ch.req_type, req_ch.data_in));
				words_accepted <= words_accepted + 1;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.ok        = rsp_ch.ok;
				got.popped    = rsp_ch.popped_data;
				got.front     = rsp_ch.front_data;
				got.back      = rsp_ch.back_data;
				got.occupancy = rsp_ch.occupancy;
				got.empty     = rsp_ch.is_empty;
				got.full      = rsp_ch.is_full;
				if (status_due.size() == 0) begin
					flag_mismatch("result word with none due (occupancy)",
						DATA_WIDTH'(got.occupancy), '0);
				end else begin
					want = status_due.pop_front();
					if (got.ok !== want.ok)
						flag_mismatch("ok", DATA_WIDTH'(got.ok), DATA_WIDTH'(want.ok));
					if (got.popped !== want.popped)
						flag_mismatch("popped_data", got.popped, want.popped);
					if (got.front !== want.front)
						flag_mismatch("front_data", got.front, want.front);
					if (got.back !== want.back)
						flag_mismatch("back_data", got.back, want.back);
					if (got.occupancy !== want.occupancy)
						flag_mismatch("occupancy", DATA_WIDTH'(got.occupancy),
							DATA_WIDTH'(want.occupancy));
					if (got.empty !== want.empty)
						flag_mismatch("is_empty", DATA_WIDTH'(got.empty),
							DATA_WIDTH'(want.empty));
					if (got.full !== want.full)
						flag_mismatch("is_full", DATA_WIDTH'(got.full),
							DATA_WIDTH'(want.full));
				end
			end
		end
	end

	// Stimulus and end of run
	initial begin : stimulus
		int                    push_pct;
		int                    phase_len;
		int                    r;
		logic [REQ_W-1:0]      kind;
		logic [DATA_WIDTH-1:0] word;

		// Directed: empty refusals, extreme words, head wrap, undefined codes
		queue_request(REQ_REPORT, '0);
		queue_request(REQ_POP_FRONT, '1);
		queue_request(REQ_POP_BACK, '1);
		queue_request(REQ_PUSH_FRONT, '1);
		queue_request(REQ_PUSH_BACK, '0);
		queue_request(REQ_PUSH_FRONT, 32'h5555_5555);
		queue_request(REQ_PUSH_BACK, 32'hAAAA_AAAA);
		queue_request(REQ_REPORT, '1);
		for (int c = REQ_REPORT + 1; c <= REQ_CODE_MAX; c++) begin
			queue_request(REQ_W'(c), $urandom);
		end
		queue_request(REQ_POP_BACK, '0);
		queue_request(REQ_POP_FRONT, '0);
		queue_request(REQ_POP_BACK, '0);
		queue_request(REQ_POP_FRONT, '0);
		queue_request(REQ_POP_FRONT, '0);
		queue_request(REQ_POP_BACK, '0);

		// Random phases biased toward filling, draining or churning
		while (total_requests < RANDOM_WORDS + 17) begin
			case ($urandom_range(0, 4))
				0: push_pct = 95;
				1: push_pct = 5;
				2: push_pct = 85;
				3: push_pct = 15;
				default: push_pct = 50;
			endcase
			phase_len = $urandom_range(10, 50);
			for (int i = 0; i < phase_len; i++) begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					kind = REQ_W'($urandom_range(REQ_REPORT + 1, REQ_CODE_MAX));
				end else if (r < 8) begin
					kind = REQ_REPORT;
				end else if ($urandom_range(0, 99) < push_pct) begin
					kind = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
				end else begin
					kind = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
				end
				if ($urandom_range(0, 7) == 0) begin
					word = $urandom_range(0, 1) ? '1 : '0;
				end else begin
					word = $urandom;
				end
				queue_request(kind, word);
			end
		end

		// Drain: all requests taken, all results back, then a short settle
		while (words_accepted < total_requests) @(posedge clk);
		while (status_due.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && status_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#1000000;
		$display("Verification failed");
		$finish;
	end

endmodule
